// ===== rtl/core/array_list_insert_delete_assert.svh =====
// Assertion macros for the array list block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef ARRAY_LIST_INSERT_DELETE_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define ALI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define ALI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ali_pkg.sv =====
// Shared types, constants and codes for the array list block.
// No dependencies; imported by every module of the block.
package ali_pkg;

  localparam int CAPACITY    = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int DATA_W      = 32;
  localparam int POS_W       = 3;
  localparam int KIND_W      = 3;
  localparam int STAT_W      = 2;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DISP_MAX    = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

  // operation codes
  localparam logic [KIND_W-1:0] K_CLEAR   = 3'd0;
  localparam logic [KIND_W-1:0] K_APPEND  = 3'd1;
  localparam logic [KIND_W-1:0] K_INSERT  = 3'd2;
  localparam logic [KIND_W-1:0] K_DELETE  = 3'd3;
  localparam logic [KIND_W-1:0] K_DISPLAY = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] item_value;
    logic [POS_W-1:0]         item_position;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } out_word_t;

  typedef struct packed {
    logic                     we;
    idx_t                     waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     re;
    idx_t                     raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_UP,
    S_PUT,
    S_DN,
    S_DRD,
    S_DEM,
    S_FIN
  } state_t;

endpackage

// ===== rtl/core/array_list_insert_delete.sv =====
// Array list top level: sequencer, element store and output register.
// Depends on ali_pkg, ali_mem, ali_ctrl and ali_obuf.
//
// Ordered list of up to CAPACITY signed 32-bit words with a live count. Each
// input word is one operation (clear, append, insert, delete, display) and
// yields one or more result words; the final one carries last. The block
// takes one operation at a time: in_ready is high only while idle. The store
// has a single read port with registered data, and every move of an element
// goes through it: insert moves the entries from the position up one slot,
// top first, before it writes the value, and delete moves the entries above
// the position down one slot. A finished result sits in the output register
// so the next operation can be taken while it waits; the sequencer stalls
// only when it has a new result and that register is still held.
module array_list_insert_delete
  import ali_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  mem_req_t                 mem_req;
  logic signed [DATA_W-1:0] rdata;
  logic                     free;
  logic                     push;
  out_word_t                push_word;

  ali_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .free      (free),
    .push      (push),
    .push_word (push_word)
  );

  ali_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  ali_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// ===== rtl/core/ali_mem.sv =====
// Element storage: one write port, one registered read port.
// Depends on ali_pkg for widths and the request struct.
module ali_mem
  import ali_pkg::*;
(
  input  logic                     clk,
  input  mem_req_t                 req,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem_r [CAPACITY];
  logic signed [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem_r[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ali_obuf.sv =====
// Output register for result words; frees the sequencer from the consumer.
// Depends on ali_pkg for the result word type.
module ali_obuf
  import ali_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_word_t push_word,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic      valid_r;
  out_word_t word_r;

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      word_r <= push_word;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== rtl/core/ali_ctrl.sv =====
// Sequencer: decodes an operation, walks the element store one entry per
// step with a shared pointer unit, keeps the count. Depends on ali_pkg.
module ali_ctrl
  import ali_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_word_t                 in_word,
  output mem_req_t                 mem_req,
  input  logic signed [DATA_W-1:0] rdata,
  input  logic                     free,
  output logic                     push,
  output out_word_t                push_word
);

  state_t            state_r, state_nxt;
  cnt_t              cnt_r, cnt_nxt;
  cnt_t              ptr_r, ptr_nxt;
  cnt_t              tgt_r, tgt_nxt;
  idx_t              wa_r, wa_nxt;
  logic              pend_r, pend_nxt;
  in_word_t          op_r, op_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  cnt_t              ptr_inc;
  cnt_t              ptr_dec;
  logic              disp_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    tgt_r    <= tgt_nxt;
    wa_r     <= wa_nxt;
    op_r     <= op_nxt;
    status_r <= status_nxt;
  end

  // shared pointer unit
  assign ptr_inc   = ptr_r + cnt_t'(1);
  assign ptr_dec   = ptr_r - cnt_t'(1);
  assign pos_c     = CMP_W'(op_r.position);
  assign cnt_c     = CMP_W'(cnt_r);
  assign disp_last = (ptr_inc == cnt_r) || (ptr_inc == cnt_t'(DISP_MAX));

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    tgt_nxt    = tgt_r;
    wa_nxt     = wa_r;
    pend_nxt   = pend_r;
    op_nxt     = op_r;
    status_nxt = status_r;

    mem_req.we    = 1'b0;
    mem_req.waddr = wa_r;
    mem_req.wdata = rdata;
    mem_req.re    = 1'b0;
    mem_req.raddr = idx_t'(ptr_r);

    push      = 1'b0;
    push_word = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_word;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        pend_nxt   = 1'b0;
        status_nxt = ST_OK;
        state_nxt  = S_FIN;
        case (op_r.kind)
          K_APPEND: begin
            if (cnt_r == cnt_t'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              ptr_nxt   = cnt_r;
              tgt_nxt   = cnt_r;
              state_nxt = S_UP;
            end
          end
          K_INSERT: begin
            if (cnt_r == cnt_t'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else if (pos_c > cnt_c) begin
              status_nxt = ST_BADPOS;
            end else begin
              ptr_nxt   = cnt_r;
              tgt_nxt   = cnt_t'(op_r.position);
              state_nxt = S_UP;
            end
          end
          K_DELETE: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (pos_c >= cnt_c) begin
              status_nxt = ST_BADPOS;
            end else begin
              ptr_nxt   = cnt_t'(op_r.position);
              state_nxt = S_DN;
            end
          end
          K_DISPLAY: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              ptr_nxt   = '0;
              state_nxt = S_DRD;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end

      // move entries up one slot, top first; read one, write the previous
      S_UP: begin
        if (pend_r) begin
          mem_req.we = 1'b1;
        end
        if (ptr_r > tgt_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_t'(ptr_dec);
          wa_nxt        = idx_t'(ptr_r);
          ptr_nxt       = ptr_dec;
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_t'(tgt_r);
        mem_req.wdata = op_r.value;
        status_nxt    = ST_OK;
        state_nxt     = S_FIN;
      end

      // move entries down one slot, stop at the last live entry
      S_DN: begin
        if (pend_r) begin
          mem_req.we = 1'b1;
        end
        if (ptr_inc < cnt_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_t'(ptr_inc);
          wa_nxt        = idx_t'(ptr_r);
          ptr_nxt       = ptr_inc;
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt   = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_FIN;
        end
      end

      S_DRD: begin
        mem_req.re = 1'b1;
        state_nxt  = S_DEM;
      end

      S_DEM: begin
        if (free) begin
          push                    = 1'b1;
          push_word.item_value    = rdata;
          push_word.item_position = POS_W'(ptr_r);
          push_word.status        = ST_OK;
          push_word.last          = disp_last;
          if (disp_last) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_inc;
            state_nxt = S_DRD;
          end
        end
      end

      S_FIN: begin
        if (free) begin
          push             = 1'b1;
          push_word.status = status_r;
          push_word.last   = 1'b1;
          state_nxt        = S_IDLE;
          if (op_r.kind == K_CLEAR) begin
            cnt_nxt = '0;
          end else if (status_r == ST_OK) begin
            if (op_r.kind == K_APPEND || op_r.kind == K_INSERT) begin
              cnt_nxt = cnt_r + cnt_t'(1);
            end else if (op_r.kind == K_DELETE) begin
              cnt_nxt = cnt_r - cnt_t'(1);
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ali_checker.sv =====
// Port-level checks for the array list block, bound to the top level.
// Depends on ali_pkg and array_list_insert_delete_assert.svh.
`include "array_list_insert_delete_assert.svh"

module ali_checker
  import ali_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  logic in_acc;
  logic out_stall;
  logic err_word;
  logic err_clean;
  logic mid_word;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign err_word  = out_valid && (out_word.status != ST_OK);
  assign err_clean = (out_word.item_value == '0) && (out_word.item_position == '0) &&
                     out_word.last;
  assign mid_word  = out_valid && !out_word.last;

  `ALI_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_word), "result word dropped")
  `ALI_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready, "ready high after accept")
  `ALI_ASSERT_IMP(a_status_fields, err_word, err_clean, "error result has display fields")
  `ALI_ASSERT_IMP(a_mid_display_ok, mid_word, out_word.status == ST_OK, "non-final error result")

endmodule

bind array_list_insert_delete ali_checker u_chk (.*);

// ===== sim/array_list_insert_delete_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the array list block: clear, append, insert, delete, display.
// Depends on ali_pkg and array_list_insert_delete; the list state is tracked here.
module array_list_insert_delete_test;
  import ali_pkg::*;

  localparam int RAND_OPS    = 132;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_CYCLES = 250;
  localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  in_word_t  pending_ops[$];
  out_word_t results_due[$];

  // list contents as the block should hold them
  logic signed [DATA_W-1:0] list_mem[CAPACITY];
  int list_len = 0;
  int gen_len = 0;

  int ops_taken = 0;
  int fault_cnt = 0;
  int stall_cycles = 0;
  int backlog_hold = 0;
  bit hold_done = 1'b0;
  in_word_t  next_op;
  out_word_t want;

  array_list_insert_delete DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  task automatic apply_list_op(input in_word_t op);
    out_word_t r;
    int j;
    int n;
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    case (op.kind)
      K_CLEAR: begin
        list_len = 0;
      end
      K_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = op.value;
          list_len++;
        end
      end
      K_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (int'(op.position) > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (j = list_len; j > int'(op.position); j--)
            list_mem[j] = list_mem[j-1];
          list_mem[op.position] = op.value;
          list_len++;
        end
      end
      K_DELETE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(op.position) >= list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (j = int'(op.position); j + 1 < list_len; j++)
            list_mem[j] = list_mem[j+1];
          list_len--;
        end
      end
      K_DISPLAY: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          n = (list_len > MAX_RESULTS) ? MAX_RESULTS : list_len;
          for (j = 0; j < n; j++) begin
            r.item_value = list_mem[j];
            r.item_position = j[POS_W-1:0];
            r.last = (j + 1 == n);
            results_due.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    results_due.push_back(r);
  endtask

  // queue one operation; track the length only to steer positions
  task automatic add_op(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] value,
                        input int position);
    in_word_t op;
    op.kind = kind;
    op.value = value;
    op.position = position[POS_W-1:0];
    pending_ops.push_back(op);
    case (kind)
      K_CLEAR: gen_len = 0;
      K_APPEND: if (gen_len < CAPACITY) gen_len++;
      K_INSERT: if (gen_len < CAPACITY && position <= gen_len) gen_len++;
      K_DELETE: if (gen_len > 0 && position < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  initial begin
    int i;
    int pick;
    int pos;
    logic [KIND_W-1:0] kind;
    logic signed [DATA_W-1:0] value;

    // directed: empty list, edges of position, extremes of value, full list
    add_op(K_DISPLAY, $urandom, 3);
    add_op(K_DELETE, $urandom, 0);
    add_op(K_INSERT, 32'sd5, 1);
    add_op(K_INSERT, 32'sh7fffffff, 0);
    add_op(K_APPEND, 32'sh80000000, 6);
    add_op(K_INSERT, -32'sd1, 2);
    add_op(K_INSERT, 32'sd0, 1);
    add_op(K_DELETE, $urandom, 4);
    add_op(K_DELETE, $urandom, 3);
    add_op(K_DELETE, $urandom, 0);
    add_op(K_DISPLAY, $urandom, 7);
    for (i = K_SPARE_LO; i <= K_SPARE_HI; i++)
      add_op(i[KIND_W-1:0], $urandom, $urandom_range(7));
    for (i = 0; i < 6; i++)
      add_op(K_APPEND, $urandom, $urandom_range(7));
    add_op(K_APPEND, $urandom, 5);
    add_op(K_INSERT, $urandom, 7);
    add_op(K_DISPLAY, $urandom, 2);
    add_op(K_DELETE, $urandom, 7);
    add_op(K_INSERT, 32'sh55aa55aa, 0);
    add_op(K_DELETE, $urandom, 0);
    add_op(K_CLEAR, $urandom, 7);
    add_op(K_DISPLAY, $urandom, 0);

    // random: mostly legal positions, the list swings between empty and full
    for (i = 0; i < RAND_OPS; i++) begin
      pick = $urandom_range(99);
      pos = $urandom_range(7);
      case ($urandom_range(7))
        0: value = 32'sh80000000;
        1: value = 32'sh7fffffff;
        2: value = -32'sd1;
        default: value = $urandom;
      endcase
      if (pick < 4) begin
        kind = K_CLEAR;
      end else if (pick < 8) begin
        kind = KIND_W'($urandom_range(K_SPARE_HI, K_SPARE_LO));
      end else if (pick < 30) begin
        kind = K_APPEND;
      end else if (pick < 55) begin
        kind = K_INSERT;
        if ($urandom_range(9) < 8) pos = $urandom_range((gen_len < 7) ? gen_len : 7);
      end else if (pick < 80) begin
        kind = K_DELETE;
        if (gen_len > 0 && $urandom_range(9) < 8) pos = $urandom_range(gen_len - 1);
      end else begin
        kind = K_DISPLAY;
      end
      add_op(kind, value, pos);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fault_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sender: no gaps while ops 60..99 go in
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_list_op(in_word);
        ops_taken <= ops_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 &&
            !(($urandom_range(99) < 32) && !(ops_taken >= 60 && ops_taken < 100))) begin
          next_op = pending_ops.pop_front();
          in_word <= next_op;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %p", $time, out_word);
          fault_cnt++;
        end else begin
          want = results_due.pop_front();
          if (out_word.item_value !== want.item_value ||
              out_word.item_position !== want.item_position ||
              out_word.status !== want.status || out_word.last !== want.last) begin
            $display("%0t: result mismatch: expected value %0d pos %0d status %0d last %0b,",
                     $time, want.item_value, want.item_position, want.status, want.last);
            $display("    actual value %0d pos %0d status %0d last %0b",
                     out_word.item_value, out_word.item_position, out_word.status,
                     out_word.last);
            fault_cnt++;
          end
        end
      end
      if (backlog_hold > 0) begin
        backlog_hold <= backlog_hold - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && ops_taken >= 130) begin
        backlog_hold <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(($urandom_range(99) < 32) && !(ops_taken >= 60 && ops_taken < 100));
      end
    end
  end

  // end the run if no word moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ===== array_list_insert_delete.f =====
+incdir+rtl/core
rtl/core/ali_pkg.sv
rtl/core/ali_mem.sv
rtl/core/ali_obuf.sv
rtl/core/ali_ctrl.sv
rtl/core/array_list_insert_delete.sv
rtl/core/ali_checker.sv
sim/array_list_insert_delete_test.sv
